>>> hw/rtl/shsd_pkg.sv
// Shared constants, data-position table and result type for the split Hamming decoder.
package shsd_pkg;

    localparam int WORD_BITS   = 26;
    localparam int FIRST_LEN   = 12;
    localparam int SMALL_LEN   = 7;
    localparam int SECOND_BASE = 12;
    localparam int THIRD_BASE  = 19;
    localparam int DATA_BITS   = 16;
    localparam int SYN1_BITS   = 4;
    localparam int SYN_BITS    = 3;
    localparam int NUM_BLOCKS  = 3;

    // Non-parity bit positions of the whole word, ascending.
    localparam logic [4:0] DATA_POS [DATA_BITS] = '{
        5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd14, 5'd16, 5'd17, 5'd18, 5'd21, 5'd23, 5'd24, 5'd25
    };

    typedef struct packed {
        logic [WORD_BITS-1:0]  corrected_word;
        logic [DATA_BITS-1:0]  data_word;
        logic [SYN1_BITS-1:0]  syndrome_first;
        logic [SYN_BITS-1:0]   syndrome_second;
        logic [SYN_BITS-1:0]   syndrome_third;
        logic [NUM_BLOCKS-1:0] corrected_flags;
        logic                  uncorrectable;
    } t_result;

endpackage

>>> hw/rtl/shsd_decode.sv
// Combinational syndrome, single-bit correction and data extraction for one 26-bit word.
module shsd_decode (
    input  logic [shsd_pkg::WORD_BITS-1:0] i_word,
    output shsd_pkg::t_result              o_result
);

    logic [shsd_pkg::FIRST_LEN-1:0] blk1;
    logic [shsd_pkg::SMALL_LEN-1:0] blk2;
    logic [shsd_pkg::SMALL_LEN-1:0] blk3;
    logic [shsd_pkg::SYN1_BITS-1:0] s1;
    logic [shsd_pkg::SYN_BITS-1:0]  s2;
    logic [shsd_pkg::SYN_BITS-1:0]  s3;
    logic                           fix1;
    logic                           bad;
    logic [shsd_pkg::FIRST_LEN-1:0] flip1;
    logic [shsd_pkg::SMALL_LEN-1:0] flip2;
    logic [shsd_pkg::SMALL_LEN-1:0] flip3;
    logic [shsd_pkg::WORD_BITS-1:0] fixed;
    logic [shsd_pkg::DATA_BITS-1:0] data;

    assign blk1 = i_word[shsd_pkg::FIRST_LEN-1:0];
    assign blk2 = i_word[shsd_pkg::SECOND_BASE +: shsd_pkg::SMALL_LEN];
    assign blk3 = i_word[shsd_pkg::THIRD_BASE +: shsd_pkg::SMALL_LEN];

    // Syndrome = XOR of 1-based positions of all set bits.
    always_comb begin
        s1 = '0;
        s2 = '0;
        s3 = '0;
        for (int k = 0; k < shsd_pkg::FIRST_LEN; k++) begin
            if (blk1[k]) begin
                s1 = s1 ^ shsd_pkg::SYN1_BITS'(k + 1);
            end
        end
        for (int k = 0; k < shsd_pkg::SMALL_LEN; k++) begin
            if (blk2[k]) begin
                s2 = s2 ^ shsd_pkg::SYN_BITS'(k + 1);
            end
            if (blk3[k]) begin
                s3 = s3 ^ shsd_pkg::SYN_BITS'(k + 1);
            end
        end
    end

    // Syndromes 13..15 point past the 12-bit block: flag, no flip.
    assign fix1 = (s1 != '0) && (s1 <= shsd_pkg::SYN1_BITS'(shsd_pkg::FIRST_LEN));
    assign bad  = (s1 > shsd_pkg::SYN1_BITS'(shsd_pkg::FIRST_LEN));

    assign flip1 = fix1 ? (shsd_pkg::FIRST_LEN'(1) << (s1 - 4'd1)) : '0;
    assign flip2 = (s2 != '0) ? (shsd_pkg::SMALL_LEN'(1) << (s2 - 3'd1)) : '0;
    assign flip3 = (s3 != '0) ? (shsd_pkg::SMALL_LEN'(1) << (s3 - 3'd1)) : '0;

    assign fixed = {blk3 ^ flip3, blk2 ^ flip2, blk1 ^ flip1};

    always_comb begin
        for (int k = 0; k < shsd_pkg::DATA_BITS; k++) begin
            data[k] = fixed[shsd_pkg::DATA_POS[k]];
        end
    end

    assign o_result.corrected_word  = fixed;
    assign o_result.data_word       = data;
    assign o_result.syndrome_first  = s1;
    assign o_result.syndrome_second = s2;
    assign o_result.syndrome_third  = s3;
    assign o_result.corrected_flags = {s3 != '0, s2 != '0, fix1};
    assign o_result.uncorrectable   = bad;

endmodule

>>> hw/rtl/split_hamming_sec_decoder_26bit.sv
// Top level: input register, decode logic and result register of the split Hamming decoder.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_codeword
//  out     | o_out_valid | i_out_ready | o_corrected_word, o_data_word, o_syndrome_*,
//          |             |             | o_corrected_flags, o_uncorrectable
//
// One transaction per cycle while the result is not stalled; outputs are registered.
// Decode (three XOR syndrome trees, one-hot flips) sits between the input register
// and the result register. Synchronous active-low reset empties both stages.
// While the result is stalled, one more transaction is taken into the input register.
module split_hamming_sec_decoder_26bit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [shsd_pkg::WORD_BITS-1:0]   i_codeword,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [shsd_pkg::WORD_BITS-1:0]   o_corrected_word,
    output logic [shsd_pkg::DATA_BITS-1:0]   o_data_word,
    output logic [shsd_pkg::SYN1_BITS-1:0]   o_syndrome_first,
    output logic [shsd_pkg::SYN_BITS-1:0]    o_syndrome_second,
    output logic [shsd_pkg::SYN_BITS-1:0]    o_syndrome_third,
    output logic [shsd_pkg::NUM_BLOCKS-1:0]  o_corrected_flags,
    output logic                             o_uncorrectable
);

    logic                           r_in_valid;
    logic [shsd_pkg::WORD_BITS-1:0] r_in_word;
    logic                           r_out_valid;
    shsd_pkg::t_result              r_out;
    shsd_pkg::t_result              n_out;
    logic                           out_free;
    logic                           in_take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    shsd_decode u_decode (
        .i_word   (r_in_word),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_codeword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_corrected_word  = r_out.corrected_word;
    assign o_data_word       = r_out.data_word;
    assign o_syndrome_first  = r_out.syndrome_first;
    assign o_syndrome_second = r_out.syndrome_second;
    assign o_syndrome_third  = r_out.syndrome_third;
    assign o_corrected_flags = r_out.corrected_flags;
    assign o_uncorrectable   = r_out.uncorrectable;

    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted transaction not held in input register");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("stalled result dropped");

    a_bad_no_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.uncorrectable) |-> !r_out.corrected_flags[0])
        else $error("uncorrectable block reported as corrected");

    a_bad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.uncorrectable ==
                         (r_out.syndrome_first > 4'(shsd_pkg::FIRST_LEN))))
        else $error("uncorrectable flag disagrees with first syndrome");

    a_small_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.corrected_flags[1] == (r_out.syndrome_second != 3'd0)) &&
                         (r_out.corrected_flags[2] == (r_out.syndrome_third != 3'd0))))
        else $error("small-block flag disagrees with its syndrome");

endmodule
